[rtl/core/szb_pkg.sv]
// ----------------------------------------------------------------------------
// szb_pkg
// Shared types and constants for the spatial zone blend selector.
// ----------------------------------------------------------------------------
package szb_pkg;

  localparam int MAX_ZONES = 16;
  localparam int SLOT_W    = 4;
  localparam int SQ_W      = 34;   // sum of three squared 17-bit offsets
  localparam int ROOT_W    = SQ_W / 2;
  localparam int QUO_W     = 15;   // falloff quotient stays below full scale
  localparam logic [15:0] FULL_BLEND = 16'h8000;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_POS    = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [SLOT_W-1:0]  slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        inner_radius;
    logic [15:0]        outer_radius;
    logic signed [15:0] zone_priority;
    logic               zone_on;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  active_zone;
    logic [15:0] blend;
  } out_item_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_SQRT = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_PICK = 6'b100000
  } state_t;

endpackage

[rtl/core/szb_sqrt.sv]
// ----------------------------------------------------------------------------
// szb_sqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module szb_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [szb_pkg::SQ_W-1:0]  value,
  output logic                      done,
  output logic [szb_pkg::ROOT_W-1:0] root
);
  import szb_pkg::*;

  logic [SQ_W-1:0]   val_r;
  logic [ROOT_W:0]   rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [4:0]        cnt_r;
  logic              run_r, done_r;
  logic [ROOT_W+2:0] rem_sh, trial;

  assign rem_sh = {rem_r, val_r[SQ_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        cnt_r  <= 5'(ROOT_W);
        val_r  <= value;
        rem_r  <= '0;
        root_r <= '0;
      end else if (run_r) begin
        val_r <= val_r << 2;
        if (rem_sh >= trial) begin
          rem_r  <= (ROOT_W+1)'(rem_sh - trial);
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[ROOT_W:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[rtl/core/szb_div.sv]
// ----------------------------------------------------------------------------
// szb_div
// Restoring divider for the falloff: (num << 15) / den with num < den.
// ----------------------------------------------------------------------------
module szb_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [15:0]              num,
  input  logic [15:0]              den,
  output logic                     done,
  output logic [szb_pkg::QUO_W-1:0] quo
);
  import szb_pkg::*;

  logic [15:0]      rem_r, den_r;
  logic [QUO_W-1:0] quo_r;
  logic [3:0]       cnt_r;
  logic             run_r, done_r;
  logic [16:0]      rem_sh;

  assign rem_sh = {rem_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 4'(QUO_W);
        rem_r <= num;
        den_r <= den;
        quo_r <= '0;
      end else if (run_r) begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_r <= 16'(rem_sh - {1'b0, den_r});
          quo_r <= {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[15:0];
          quo_r <= {quo_r[QUO_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[rtl/core/spatial_zone_blend_selector.sv]
// ----------------------------------------------------------------------------
// spatial_zone_blend_selector
// Zone table with a sequencer that walks the slots for each listener update.
// ----------------------------------------------------------------------------
// Every accepted transaction yields one result, strobed on out_valid for a
// single cycle; the receiver cannot stall it. Zone write and remove answer
// in the cycle after acceptance, as does a position update while the manager is disabled.
// A position update visits all 16 slots: it skips each empty or disabled
// slot, and for an enabled slot it inspects it, squares the three offsets on
// the shared 17x17 multiplier, takes the bit-serial square root, runs the
// serial divider inside the falloff band and then compares. busy stays high
// throughout and the result is strobed in the cycle busy falls.
module spatial_zone_blend_selector (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  szb_pkg::in_item_t  in_item,
  output logic               out_valid,
  output szb_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import szb_pkg::*;

  // zone table
  logic               zvalid_r [MAX_ZONES];
  logic               zon_r    [MAX_ZONES];
  logic signed [15:0] zcx_r    [MAX_ZONES];
  logic signed [15:0] zcy_r    [MAX_ZONES];
  logic signed [15:0] zcz_r    [MAX_ZONES];
  logic [15:0]        zin_r    [MAX_ZONES];
  logic [15:0]        zout_r   [MAX_ZONES];
  logic signed [15:0] zrank_r  [MAX_ZONES];

  state_t state_r, state_nxt;
  logic [SLOT_W-1:0]  idx_r, idx_nxt;
  logic [1:0]         axis_r, axis_nxt;
  logic signed [15:0] lx_r, ly_r, lz_r;
  logic [32:0]        prod_r, prod_nxt;
  logic [SQ_W-1:0]    acc_r, acc_nxt;
  logic [15:0]        blend_r, blend_nxt;
  logic [4:0]         best_zone_r, best_zone_nxt;
  logic [15:0]        best_blend_r, best_blend_nxt;
  logic signed [15:0] best_rank_r, best_rank_nxt;
  logic [4:0]         cur_zone_r, cur_zone_nxt;
  logic [15:0]        cur_blend_r, cur_blend_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               enable_r;

  logic               accept;
  logic signed [15:0] lsel, csel;
  logic signed [16:0] diff;
  logic signed [33:0] sq;
  logic               sq_start, sq_done, dv_start, dv_done;
  logic [ROOT_W-1:0]  dist_root;
  logic [QUO_W-1:0]   quo;
  logic [15:0]        inner, outer;
  logic               last;

  assign accept = start && (state_r == ST_IDLE);
  assign inner  = zin_r[idx_r];
  assign outer  = zout_r[idx_r];
  assign last   = (idx_r == SLOT_W'(MAX_ZONES - 1));

  always_comb begin
    case (axis_r)
      2'd0:    begin lsel = lx_r; csel = zcx_r[idx_r]; end
      2'd1:    begin lsel = ly_r; csel = zcy_r[idx_r]; end
      default: begin lsel = lz_r; csel = zcz_r[idx_r]; end
    endcase
  end

  assign diff = {lsel[15], lsel} - {csel[15], csel};
  assign sq   = diff * diff;

  szb_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (acc_r + {1'b0, prod_r}),
    .done  (sq_done),
    .root  (dist_root)
  );

  szb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (16'(outer - dist_root[15:0])),
    .den   (outer - inner),
    .done  (dv_done),
    .quo   (quo)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    axis_nxt       = axis_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    blend_nxt      = blend_r;
    best_zone_nxt  = best_zone_r;
    best_blend_nxt = best_blend_r;
    best_rank_nxt  = best_rank_r;
    cur_zone_nxt   = cur_zone_r;
    cur_blend_nxt  = cur_blend_r;
    out_valid_nxt  = 1'b0;
    sq_start       = 1'b0;
    dv_start       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_item.kind)
            KIND_WRITE: out_valid_nxt = 1'b1;
            KIND_REMOVE: begin
              out_valid_nxt = 1'b1;
              if (cur_zone_r == {1'b0, in_item.slot} + 5'd1) begin
                cur_zone_nxt  = '0;
                cur_blend_nxt = '0;
              end
            end
            KIND_POS: begin
              if (enable_r) begin
                state_nxt      = ST_SCAN;
                idx_nxt        = '0;
                best_zone_nxt  = '0;
                best_blend_nxt = '0;
                best_rank_nxt  = '0;
              end else begin
                out_valid_nxt = 1'b1;
                cur_zone_nxt  = '0;
                cur_blend_nxt = '0;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        if (zvalid_r[idx_r] && zon_r[idx_r]) begin
          state_nxt = ST_MUL;
          axis_nxt  = '0;
          acc_nxt   = '0;
        end else if (last) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          cur_zone_nxt  = best_zone_r;
          cur_blend_nxt = best_blend_r;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end
      ST_MUL: begin
        // square one axis per cycle, accumulate the previous product
        prod_nxt = sq[32:0];
        if (axis_r != 2'd0)
          acc_nxt = acc_r + {1'b0, prod_r};
        axis_nxt = axis_r + 2'd1;
        if (axis_r == 2'd2) begin
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (!sq_start && axis_r == 2'd3) begin
          sq_start = 1'b1;
          axis_nxt = '0;
        end else if (sq_done) begin
          if ({1'b0, dist_root} <= {2'b00, inner}) begin
            blend_nxt = FULL_BLEND;
            state_nxt = ST_PICK;
          end else if ({1'b0, dist_root} >= {2'b00, outer}) begin
            blend_nxt = '0;
            state_nxt = ST_PICK;
          end else begin
            dv_start  = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (dv_done) begin
          blend_nxt = {1'b0, quo};
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        if (blend_r != 16'd0 && (blend_r > best_blend_r ||
            (blend_r == best_blend_r && zrank_r[idx_r] > best_rank_r))) begin
          best_zone_nxt  = {1'b0, idx_r} + 5'd1;
          best_blend_nxt = blend_r;
          best_rank_nxt  = zrank_r[idx_r];
        end
        if (last) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          cur_zone_nxt  = best_zone_nxt;
          cur_blend_nxt = best_blend_nxt;
        end else begin
          state_nxt = ST_SCAN;
          idx_nxt   = idx_r + SLOT_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // disabling the manager drops the reported zone at once
    if (cfg_we && !cfg_wdata) begin
      cur_zone_nxt  = '0;
      cur_blend_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      enable_r    <= 1'b1;
      cur_zone_r  <= '0;
      cur_blend_r <= '0;
      for (int i = 0; i < MAX_ZONES; i++) zvalid_r[i] <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cur_zone_r  <= cur_zone_nxt;
      cur_blend_r <= cur_blend_nxt;
      if (accept && in_item.kind == KIND_WRITE)  zvalid_r[in_item.slot] <= 1'b1;
      if (accept && in_item.kind == KIND_REMOVE) zvalid_r[in_item.slot] <= 1'b0;
      if (cfg_we) enable_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    prod_r       <= prod_nxt;
    acc_r        <= acc_nxt;
    blend_r      <= blend_nxt;
    best_zone_r  <= best_zone_nxt;
    best_blend_r <= best_blend_nxt;
    best_rank_r  <= best_rank_nxt;
    // the last MUL cycle leaves axis at 3, which arms the root start
    axis_r       <= (state_r == ST_MUL && axis_r == 2'd2) ? 2'd3 : axis_nxt;
    if (accept) begin
      lx_r <= in_item.pos_x;
      ly_r <= in_item.pos_y;
      lz_r <= in_item.pos_z;
    end
    if (accept && in_item.kind == KIND_WRITE) begin
      zon_r[in_item.slot]   <= in_item.zone_on;
      zcx_r[in_item.slot]   <= in_item.pos_x;
      zcy_r[in_item.slot]   <= in_item.pos_y;
      zcz_r[in_item.slot]   <= in_item.pos_z;
      zin_r[in_item.slot]   <= in_item.inner_radius;
      zout_r[in_item.slot]  <= in_item.outer_radius;
      zrank_r[in_item.slot] <= in_item.zone_priority;
    end
  end

  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_item.active_zone = cur_zone_r;
  assign out_item.blend       = cur_blend_r;

endmodule

[rtl/core/szb_checker.sv]
// ----------------------------------------------------------------------------
// szb_checker
// Port-level assertions for the spatial zone blend selector.
// ----------------------------------------------------------------------------
module szb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input szb_pkg::in_item_t  in_item,
  input logic               out_valid,
  input szb_pkg::out_item_t out_item
);
  import szb_pkg::*;

  // a result only follows an accepted transaction or running work
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without a transaction");

  // table edits answer in the next cycle
  a_edit_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.kind != KIND_POS) |=> (out_valid && !busy))
    else $error("table edit did not answer at once");

  // no zone means no blend
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.active_zone == 5'd0) |-> (out_item.blend == 16'd0))
    else $error("blend without zone");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.active_zone <= 5'(MAX_ZONES) &&
                   out_item.blend <= FULL_BLEND))
    else $error("result out of range");

endmodule

bind spatial_zone_blend_selector szb_checker u_szb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
